/* hw/rtl/rwl_pkg.sv */
// Shared types and codes for the reader/writer lock arbiter.
`default_nettype none
package rwl_pkg;

  localparam int ID_W    = 8;
  localparam int CNT_W   = 8;
  localparam int WAIT_W  = 5;

  typedef enum logic [1:0] {
    CMD_ACQ_EX  = 2'd0,
    CMD_ACQ_SH  = 2'd1,
    CMD_REL_EX  = 2'd2,
    CMD_REL_SH  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    EV_GRANTED  = 3'd0,
    EV_QUEUED   = 3'd1,
    EV_WAITER   = 3'd2,
    EV_RELEASED = 3'd3,
    EV_ERROR    = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    event_t              kind;
    logic [ID_W-1:0]     id;
    logic                shared;
    logic [CNT_W-1:0]    owners;
    logic [WAIT_W-1:0]   waiting;
    logic                last;
  } res_t;

endpackage
`default_nettype wire

/* hw/rtl/rwl_ram.sv */
// Generic single-write, single-read memory with registered read data.
`default_nettype none
module rwl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rwl_ctrl.sv */
// Lock state, request decisions and the grant walk over the wait queue.
`default_nettype none
module rwl_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int MAX_READERS = 255,
  localparam int HW = $clog2(QUEUE_DEPTH),
  localparam int KB = (ID_BITS < rwl_pkg::ID_W) ? ID_BITS : rwl_pkg::ID_W,
  localparam int EW = KB + 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                cmd,
  input  wire logic [rwl_pkg::ID_W-1:0]  requester_id,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  output rwl_pkg::res_t                  res,
  output logic                           wr_en,
  output logic [HW-1:0]                  wr_addr,
  output logic [EW-1:0]                  wr_data,
  output logic                           rd_en,
  output logic [HW-1:0]                  rd_addr,
  input  wire logic [EW-1:0]             rd_data
);

  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = $clog2(MAX_READERS + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);
  localparam logic [RW-1:0] RD_MAX   = RW'(MAX_READERS);
  localparam logic [HW-1:0] HEAD_TOP = HW'(QUEUE_DEPTH - 1);

  rwl_pkg::state_t state, state_next;
  logic [HW-1:0]   head, head_next;
  logic [FW-1:0]   fill, fill_next;
  logic            wh, wh_next;
  logic [RW-1:0]   rt, rt_next;
  rwl_pkg::res_t   pend, pend_next;
  logic            pend_valid, pend_valid_next;

  logic [KB-1:0]   id_keep;
  logic [FW:0]     tail_sum;
  logic [HW-1:0]   tail;
  logic [HW-1:0]   head_inc;
  logic [FW-1:0]   fill_dec;
  logic [RW-1:0]   rt_inc;
  logic [RW-1:0]   rt_dec;
  logic            e_shared;
  rwl_pkg::cmd_t   cmd_c;

  assign cmd_c    = rwl_pkg::cmd_t'(cmd);
  assign id_keep  = requester_id[KB-1:0];
  assign tail_sum = (FW + 1)'(head) + (FW + 1)'(fill);
  assign tail     = (tail_sum >= (FW + 1)'(QUEUE_DEPTH)) ?
                    HW'(tail_sum - (FW + 1)'(QUEUE_DEPTH)) : HW'(tail_sum);
  assign head_inc = (head == HEAD_TOP) ? '0 : head + 1'b1;
  assign fill_dec = fill - 1'b1;
  assign rt_inc   = rt + 1'b1;
  assign rt_dec   = rt - 1'b1;
  assign e_shared = rd_data[EW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rwl_pkg::ST_IDLE;
      head       <= '0;
      fill       <= '0;
      wh         <= 1'b0;
      rt         <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      fill       <= fill_next;
      wh         <= wh_next;
      rt         <= rt_next;
      pend_valid <= pend_valid_next;
    end
    pend <= pend_next;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    fill_next       = fill;
    wh_next         = wh;
    rt_next         = rt;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    res             = pend;
    wr_en           = 1'b0;
    wr_addr         = tail;
    wr_data         = {cmd_c == rwl_pkg::CMD_ACQ_SH, id_keep};
    rd_en           = 1'b0;
    rd_addr         = head;

    unique case (state)
      rwl_pkg::ST_IDLE: begin
        in_ready    = res_ready;
        res.kind    = rwl_pkg::EV_ERROR;
        res.id      = rwl_pkg::ID_W'(id_keep);
        res.shared  = (cmd_c == rwl_pkg::CMD_ACQ_SH) || (cmd_c == rwl_pkg::CMD_REL_SH);
        res.owners  = rwl_pkg::CNT_W'(rt);
        res.waiting = rwl_pkg::WAIT_W'(fill);
        res.last    = 1'b1;
        if (in_valid && res_ready) begin
          res_valid = 1'b1;
          unique case (cmd_c)
            rwl_pkg::CMD_ACQ_EX, rwl_pkg::CMD_ACQ_SH: begin
              if (!wh && fill == '0 && (cmd_c == rwl_pkg::CMD_ACQ_SH || rt == '0)) begin
                if (cmd_c == rwl_pkg::CMD_ACQ_EX) begin
                  wh_next  = 1'b1;
                  res.kind = rwl_pkg::EV_GRANTED;
                end else if (rt != RD_MAX) begin
                  rt_next    = rt_inc;
                  res.owners = rwl_pkg::CNT_W'(rt_inc);
                  res.kind   = rwl_pkg::EV_GRANTED;
                end
              end else if (fill != FILL_MAX) begin
                wr_en       = 1'b1;
                fill_next   = fill + 1'b1;
                res.waiting = rwl_pkg::WAIT_W'(fill + 1'b1);
                res.kind    = rwl_pkg::EV_QUEUED;
              end
            end
            rwl_pkg::CMD_REL_EX: begin
              if (wh && rt == '0) begin
                wh_next  = 1'b0;
                res.kind = rwl_pkg::EV_RELEASED;
                if (fill != '0) begin
                  // start the walk: fetch the head waiter, result comes later
                  res_valid       = 1'b0;
                  rd_en           = 1'b1;
                  pend_valid_next = 1'b0;
                  state_next      = rwl_pkg::ST_WALK;
                end
              end
            end
            rwl_pkg::CMD_REL_SH: begin
              if (rt != '0 && !wh) begin
                rt_next    = rt_dec;
                res.owners = rwl_pkg::CNT_W'(rt_dec);
                res.kind   = rwl_pkg::EV_RELEASED;
                if (rt_dec == '0 && fill != '0) begin
                  res_valid       = 1'b0;
                  rd_en           = 1'b1;
                  pend_valid_next = 1'b0;
                  state_next      = rwl_pkg::ST_WALK;
                end
              end
            end
          endcase
        end
      end

      rwl_pkg::ST_WALK: begin
        // rd_data holds the entry at head; a shared grant is held back in
        // pend until the next entry shows whether it is the last one
        if (res_ready) begin
          if (pend_valid && !e_shared) begin
            res_valid  = 1'b1;
            res.last   = 1'b1;
            state_next = rwl_pkg::ST_IDLE;
          end else if (!pend_valid && !e_shared) begin
            res_valid   = 1'b1;
            res.kind    = rwl_pkg::EV_WAITER;
            res.id      = rwl_pkg::ID_W'(rd_data[KB-1:0]);
            res.shared  = 1'b0;
            res.owners  = rwl_pkg::CNT_W'(rt);
            res.waiting = rwl_pkg::WAIT_W'(fill_dec);
            res.last    = 1'b1;
            head_next   = head_inc;
            fill_next   = fill_dec;
            wh_next     = 1'b1;
            state_next  = rwl_pkg::ST_IDLE;
          end else begin
            res_valid         = pend_valid;
            res.last          = 1'b0;
            head_next         = head_inc;
            fill_next         = fill_dec;
            rt_next           = rt_inc;
            pend_valid_next   = 1'b1;
            pend_next.kind    = rwl_pkg::EV_WAITER;
            pend_next.id      = rwl_pkg::ID_W'(rd_data[KB-1:0]);
            pend_next.shared  = 1'b1;
            pend_next.owners  = rwl_pkg::CNT_W'(rt_inc);
            pend_next.waiting = rwl_pkg::WAIT_W'(fill_dec);
            pend_next.last    = 1'b0;
            if (fill_dec == '0 || rt_inc == RD_MAX) begin
              state_next = rwl_pkg::ST_FLUSH;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_inc;
            end
          end
        end
      end

      rwl_pkg::ST_FLUSH: begin
        res.last = 1'b1;
        if (res_ready) begin
          res_valid  = 1'b1;
          state_next = rwl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rwl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/fifo_reader_writer_lock.sv */
// Top level of the reader/writer lock arbiter with a FIFO of waiters.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_ready   cmd, requester_id
//   out      out  out_valid/out_ready event_kind, granted_id, grant_shared,
//                                     owner_count, waiting_count, last
//
// A request that gives one result is decided combinationally and lands in the
// output register; the next request is taken in the cycle that result leaves.
// A release that hands the lock to waiters reads the queue memory at the
// head and walks it in the WALK state, one memory read per waiter; a run of
// shared waiters may end in FLUSH. Reset clears the lock state at once; the
// queue memory needs no clearing. A stalled output holds the control in place.
`default_nettype none
module fifo_reader_writer_lock #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int MAX_READERS = 255
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    cmd,
  input  wire logic [rwl_pkg::ID_W-1:0]      requester_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         event_kind,
  output logic [rwl_pkg::ID_W-1:0]           granted_id,
  output logic                               grant_shared,
  output logic [rwl_pkg::CNT_W-1:0]          owner_count,
  output logic [rwl_pkg::WAIT_W-1:0]         waiting_count,
  output logic                               last
);

  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int KB = (ID_BITS < rwl_pkg::ID_W) ? ID_BITS : rwl_pkg::ID_W;
  localparam int EW = KB + 1;

  logic            res_valid;
  logic            res_ready;
  rwl_pkg::res_t   res;
  rwl_pkg::res_t   out_res;
  logic            wr_en;
  logic [HW-1:0]   wr_addr;
  logic [EW-1:0]   wr_data;
  logic            rd_en;
  logic [HW-1:0]   rd_addr;
  logic [EW-1:0]   rd_data;

  rwl_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .MAX_READERS (MAX_READERS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .requester_id (requester_id),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  rwl_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: load when empty or draining
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign event_kind    = out_res.kind;
  assign granted_id    = out_res.id;
  assign grant_shared  = out_res.shared;
  assign owner_count   = out_res.owners;
  assign waiting_count = out_res.waiting;
  assign last          = out_res.last;

endmodule
`default_nettype wire
